/* sv/vmms_pkg.sv */
// ----------------------------------------------------------------------------
// vmms_pkg
// Shared types and constants for the vector min/max/sum/deviation reducer.
// ----------------------------------------------------------------------------
package vmms_pkg;

    localparam logic [1:0] MODE_MIN = 2'd0;
    localparam logic [1:0] MODE_MAX = 2'd1;
    localparam logic [1:0] MODE_SUM = 2'd2;
    localparam logic [1:0] MODE_SD  = 2'd3;

    localparam logic CFG_MODE = 1'b0;
    localparam logic CFG_MEAN = 1'b1;

    // Classified word passed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] sample;
        logic [32:0] diff;     // sample minus mean, 33 bits signed
        logic        last;
    } t_item;

endpackage

/* sv/vmms_front.sv */
// ----------------------------------------------------------------------------
// vmms_front
// Accepts sample words, registers each with its mode and forms the difference to mean.
// ----------------------------------------------------------------------------
module vmms_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [31:0]          i_sample,
    input  logic                 i_last,
    input  logic [1:0]           i_mode,
    input  logic [31:0]          i_mean,
    output logic                 o_valid,
    input  logic                 i_ready,
    output vmms_pkg::t_item      o_item
);
    logic            r_valid;
    vmms_pkg::t_item r_item;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item.mode   <= i_mode;
            r_item.sample <= i_sample;
            r_item.diff   <= {i_sample[31], i_sample} - {i_mean[31], i_mean};
            r_item.last   <= i_last;
        end
    end
endmodule

/* sv/vmms_fifo.sv */
// ----------------------------------------------------------------------------
// vmms_fifo
// Two-entry queue between front and back parts.
// ----------------------------------------------------------------------------
module vmms_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vmms_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output vmms_pkg::t_item o_item
);
    vmms_pkg::t_item r_mem [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_cnt;
    logic            w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n) begin
            assert (r_cnt != 2'd3) else $error("queue count out of range");
        end
    end
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == 2'd2 |-> !o_ready) else $error("queue overrun");
    a_cnt_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && !w_push) |=> r_cnt == $past(r_cnt) - 2'd1) else $error("count slip");
    a_cnt_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 2'd1) else $error("count slip");
endmodule

/* sv/vmms_back.sv */
// ----------------------------------------------------------------------------
// vmms_back
// Folds words into running state; at the last word of a deviation vector runs divide and square root.
// ----------------------------------------------------------------------------
module vmms_back #(
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vmms_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [63:0]     o_result_value,
    output logic            o_saturated,
    output logic [20:0]     o_element_total
);
    localparam logic [20:0] MaxCnt = 21'(MAX_ELEMENTS);
    localparam logic [1:0] ST_ACC = 2'd0, ST_SQR = 2'd1, ST_DIV = 2'd2, ST_ROOT = 2'd3;

    logic [1:0]  r_st;
    logic [31:0] r_ext;
    logic [63:0] r_acc;
    logic [20:0] r_cnt;
    logic        r_sat, r_first;

    // squaring stage registers
    logic        r_sq_v, r_sq_last;
    logic [63:0] r_sq;
    logic        r_sq_sat;
    logic [1:0]  r_sq_mode;

    // divider / root
    logic [1:0]  r_fmode;
    logic [63:0] r_rem, r_quo;
    logic [20:0] r_den;
    logic [5:0]  r_i;
    logic [63:0] r_v, r_root, r_bit;

    logic        r_ov;
    logic [63:0] r_ores;
    logic        r_osat;
    logic [20:0] r_ocnt;

    logic        w_take;
    logic [31:0] w_d;
    logic        w_dsat;
    logic [31:0] w_mag;
    logic signed [63:0] w_s64;
    logic [64:0] w_sum;
    logic [64:0] w_part;
    logic [63:0] w_rb;

    assign o_ready = (r_st == ST_ACC) && !r_sq_v;
    assign w_take  = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_result_value  = r_ores;
    assign o_saturated     = r_osat;
    assign o_element_total = r_ocnt;

    always_comb begin
        w_dsat = 1'b0;
        w_d    = i_item.diff[31:0];
        if (i_item.diff[32] != i_item.diff[31]) begin
            w_dsat = 1'b1;
            w_d    = i_item.diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        w_mag = w_d[31] ? (32'd0 - w_d) : w_d;
        w_s64 = {{32{i_item.sample[31]}}, i_item.sample};
        w_sum = {r_acc[63], r_acc} + {w_s64[63], w_s64};
        w_part = {r_v, r_rem[r_i]};
        w_rb  = r_root + r_bit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_ACC; r_ext <= '0; r_acc <= '0; r_cnt <= '0;
            r_sat <= 1'b0; r_first <= 1'b1; r_sq_v <= 1'b0; r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready) r_ov <= 1'b0;
            r_sq_v <= 1'b0;
            unique case (r_st)
                ST_ACC: begin
                    if (w_take) begin
                        if (r_cnt < MaxCnt) r_cnt <= r_cnt + 21'd1;
                        else r_sat <= 1'b1;
                        r_first <= 1'b0;
                        case (i_item.mode)
                            vmms_pkg::MODE_MIN, vmms_pkg::MODE_MAX: begin
                                if (r_first) r_ext <= i_item.sample;
                                else if (i_item.mode == vmms_pkg::MODE_MIN &&
                                         $signed(i_item.sample) < $signed(r_ext))
                                    r_ext <= i_item.sample;
                                else if (i_item.mode == vmms_pkg::MODE_MAX &&
                                         $signed(i_item.sample) > $signed(r_ext))
                                    r_ext <= i_item.sample;
                            end
                            vmms_pkg::MODE_SUM: begin
                                if (w_sum[64] != w_sum[63]) begin
                                    r_sat <= 1'b1;
                                    r_acc <= w_sum[64] ? 64'h8000_0000_0000_0000
                                                       : 64'h7FFF_FFFF_FFFF_FFFF;
                                end else r_acc <= w_sum[63:0];
                            end
                            default: ;
                        endcase
                        r_sq_v    <= 1'b1;
                        r_sq_mode <= i_item.mode;
                        r_sq_last <= i_item.last;
                        r_sq      <= {32'd0, w_mag} * {32'd0, w_mag} >> 16;
                        r_sq_sat  <= w_dsat;
                    end
                    if (r_sq_v) begin
                        if (r_sq_mode == vmms_pkg::MODE_SD) begin
                            if (r_sq_sat) r_sat <= 1'b1;
                            if ($signed(r_acc) > $signed(64'h7FFF_FFFF_FFFF_FFFF - r_sq)) begin
                                r_acc <= 64'h7FFF_FFFF_FFFF_FFFF;
                                r_sat <= 1'b1;
                            end else r_acc <= r_acc + r_sq;
                        end
                        if (r_sq_last) begin
                            r_fmode <= r_sq_mode;
                            r_st    <= ST_SQR;
                        end
                    end
                end
                ST_SQR: begin
                    // latch final state, start the divide or register the min/max/sum result
                    r_rem <= (!r_acc[63] && r_acc != 64'd0 && r_cnt != 21'd0) ? r_acc : 64'd0;
                    r_quo <= '0;
                    r_den <= (r_cnt == 21'd0) ? 21'd1 : r_cnt;
                    r_i   <= 6'd63;
                    r_v   <= '0;
                    if (r_fmode == vmms_pkg::MODE_SD) r_st <= ST_DIV;
                    else if (!r_ov) begin
                        r_ov   <= 1'b1;
                        r_ores <= (r_fmode == vmms_pkg::MODE_SUM) ? r_acc
                                  : {{32{r_ext[31]}}, r_ext};
                        r_osat <= r_sat; r_ocnt <= r_cnt;
                        r_st <= ST_ACC;
                        r_ext <= '0; r_acc <= '0; r_cnt <= '0; r_sat <= 1'b0; r_first <= 1'b1;
                    end
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit a cycle
                    if (w_part >= {44'd0, r_den}) begin
                        r_v <= 64'(w_part - {44'd0, r_den});
                        r_quo[r_i] <= 1'b1;
                    end else r_v <= w_part[63:0];
                    if (r_i == 6'd0) begin
                        r_st   <= ST_ROOT;
                        r_root <= '0;
                        r_bit  <= 64'h4000_0000_0000_0000;
                    end else r_i <= r_i - 6'd1;
                    if (r_i == 6'd0) r_rem <= '0;
                end
                ST_ROOT: begin
                    // The step index is still zero on the first cycle, when the
                    // clamped quotient is loaded as the radicand.
                    if (r_i == 6'd0) begin
                        r_rem <= ((r_quo > 64'h0000_7FFF_FFFF_FFFF) ? 64'h0000_7FFF_FFFF_FFFF
                                                                   : r_quo) << 16;
                        r_i   <= 6'd1;
                    end else if (r_bit != 64'd0) begin
                        if (r_rem >= w_rb) begin
                            r_rem  <= r_rem - w_rb;
                            r_root <= (r_root >> 1) + r_bit;
                        end else r_root <= r_root >> 1;
                        r_bit <= r_bit >> 2;
                    end else if (!r_ov) begin
                        r_ov   <= 1'b1;
                        r_ores <= r_root;
                        r_osat <= r_sat; r_ocnt <= r_cnt;
                        r_st <= ST_ACC;
                        r_ext <= '0; r_acc <= '0; r_cnt <= '0; r_sat <= 1'b0; r_first <= 1'b1;
                    end
                end
                default: r_st <= ST_ACC;
            endcase
        end
    end

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= MaxCnt) else $error("element count beyond limit");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st != ST_ACC |-> !o_ready) else $error("accepting while finishing");
    a_ohold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> r_ov && $stable(r_ores)) else $error("result dropped");
    a_tot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> r_ocnt != 21'd0) else $error("empty result");
endmodule

/* sv/vector_min_max_sum_stddev.sv */
// ----------------------------------------------------------------------------
// vector_min_max_sum_stddev
// Reduces a vector to its minimum, maximum, sum or standard deviation.
// ----------------------------------------------------------------------------
// Usage: sample words enter on i_valid/o_ready with i_last marking the final
// element of a vector. Configuration (mode, mean) is to be written on the
// i_cfg_valid/o_cfg_ready channel while the block is idle, which the block
// itself does not enforce; the channel is always ready. While a vector streams
// in, the back part takes a new sample only once its squaring stage has passed
// on the last one. After the last word, min, max and sum results are
// registered from the running state; the standard deviation adds a restoring
// divide and a 32-step square root, during which the back part takes no new
// sample.
// One result word leaves on o_valid/i_ready per vector. When the receiver
// stalls, the result register holds and the finishing sequencer waits, and
// the two-entry queue and front register fill before o_ready drops.
// Reset clears the mode and mean to zero and all running state; the next
// sample starts a new vector.
// ----------------------------------------------------------------------------
module vector_min_max_sum_stddev #(
    parameter int MAX_ELEMENTS = 1048576
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_sample,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_result_value,
    output logic        o_saturated,
    output logic [20:0] o_element_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [1:0]  r_mode;
    logic [31:0] r_mean;
    logic            w_fv, w_fr, w_qv, w_qr;
    vmms_pkg::t_item w_fi, w_qi;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= vmms_pkg::MODE_MIN;
            r_mean <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                vmms_pkg::CFG_MODE: r_mode <= i_cfg_data[1:0];
                vmms_pkg::CFG_MEAN: r_mean <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vmms_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_sample, .i_last,
        .i_mode(r_mode), .i_mean(r_mean),
        .o_valid(w_fv), .i_ready(w_fr), .o_item(w_fi)
    );

    vmms_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_item(w_fi),
        .o_valid(w_qv), .i_ready(w_qr), .o_item(w_qi)
    );

    vmms_back #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_item(w_qi),
        .o_valid, .i_ready, .o_result_value, .o_saturated, .o_element_total
    );
endmodule

/* dv/tb_vector_min_max_sum_stddev.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_min_max_sum_stddev
// Streams sample vectors into the reducer under every mode and several means,
// predicts each vector's min, max, sum or deviation and compares every result
// word field by field, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_vector_min_max_sum_stddev;

    localparam int  RUN_LIMIT   = 600000;
    localparam int  DRAIN_WAIT  = 150;
    localparam int  HOLD_CYCLES = 400;
    localparam int  RANDOM_ITEMS = 1030;
    localparam int  CAP_ELEMENTS = 1048576;

    typedef struct {
        logic [63:0] value;
        logic        sat;
        logic [20:0] total;
    } t_vector_result;

    // Keeps its own copy of the reducer's registers and running state.
    class reduction_scoreboard;
        logic [1:0]        mode_reg;
        logic [31:0]       mean_reg;
        logic signed [31:0] extreme;
        longint            acc;
        int unsigned       count;
        bit                sat_seen;
        bit                first;
        t_vector_result    expected_q[$];

        function new();
            mode_reg = vmms_pkg::MODE_MIN;
            mean_reg = '0;
            clear_vector();
        endfunction

        function void clear_vector();
            extreme  = '0;
            acc      = 0;
            count    = 0;
            sat_seen = 0;
            first    = 1;
        endfunction

        function void set_reg(logic idx, logic [31:0] data);
            if (idx == vmms_pkg::CFG_MODE) mode_reg = data[1:0];
            else mean_reg = data;
        endfunction

        function logic [63:0] floor_sqrt(logic [63:0] v);
            logic [31:0] r;
            logic [63:0] t;
            r = '0;
            for (int i = 31; i >= 0; i--) begin
                t = {32'd0, r | (32'd1 << i)};
                if (t * t <= v) r = r | (32'd1 << i);
            end
            return {32'd0, r};
        endfunction

        function void note_sample(logic [31:0] sample, logic last);
            longint s;
            longint d;
            longint sq;
            logic [63:0] mag;
            logic [63:0] variance;
            t_vector_result res;
            s = longint'($signed(sample));
            if (mode_reg == vmms_pkg::MODE_MIN || mode_reg == vmms_pkg::MODE_MAX) begin
                if (first) extreme = sample;
                else if (mode_reg == vmms_pkg::MODE_MIN && s < extreme) extreme = sample;
                else if (mode_reg == vmms_pkg::MODE_MAX && s > extreme) extreme = sample;
            end else if (mode_reg == vmms_pkg::MODE_SUM) begin
                if (s > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - s) begin
                    acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                    sat_seen = 1;
                end else if (s < 0 && acc < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - s) begin
                    acc = -64'sh7FFF_FFFF_FFFF_FFFF - 1;
                    sat_seen = 1;
                end else begin
                    acc = acc + s;
                end
            end else begin
                d = s - longint'($signed(mean_reg));
                if (d > 64'sd2147483647) begin
                    d = 64'sd2147483647;
                    sat_seen = 1;
                end
                if (d < -64'sd2147483648) begin
                    d = -64'sd2147483648;
                    sat_seen = 1;
                end
                mag = (d < 0) ? -d : d;
                sq = longint'((mag * mag) >> 16);
                if (acc > 64'sh7FFF_FFFF_FFFF_FFFF - sq) begin
                    acc = 64'sh7FFF_FFFF_FFFF_FFFF;
                    sat_seen = 1;
                end else begin
                    acc = acc + sq;
                end
            end
            first = 0;
            if (count < CAP_ELEMENTS) count++;
            else sat_seen = 1;
            if (!last) return;
            if (mode_reg == vmms_pkg::MODE_MIN || mode_reg == vmms_pkg::MODE_MAX) begin
                res.value = {{32{extreme[31]}}, extreme};
            end else if (mode_reg == vmms_pkg::MODE_SUM) begin
                res.value = acc;
            end else begin
                variance = '0;
                if (acc > 0 && count != 0) variance = 64'(acc) / 64'(count);
                if (variance > (64'd1 << 47) - 1) variance = (64'd1 << 47) - 1;
                res.value = floor_sqrt(variance << 16);
            end
            res.sat   = sat_seen;
            res.total = count[20:0];
            expected_q.push_back(res);
            clear_vector();
        endfunction

        // Returns an empty string when the word matches the oldest expectation.
        function string check_result(logic [63:0] value, logic sat, logic [20:0] total);
            t_vector_result e;
            if (expected_q.size() == 0)
                return $sformatf("unexpected result word value=%h", value);
            e = expected_q.pop_front();
            if (value !== e.value || sat !== e.sat || total !== e.total)
                return $sformatf("got value=%h sat=%b total=%0d, want value=%h sat=%b total=%0d",
                                 value, sat, total, e.value, e.sat, e.total);
            return "";
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [31:0] i_sample;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_result_value;
    logic        o_saturated;
    logic [20:0] o_element_total;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;

    reduction_scoreboard sb;
    int  mismatches;
    int  cycles;
    bit  quiet;
    bit  hold_request;
    int  sent;

    vector_min_max_sum_stddev uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_result_value (o_result_value),
        .o_saturated    (o_saturated),
        .o_element_total(o_element_total),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report(string msg);
        mismatches++;
        $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= RUN_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Result monitor: the handshake is sampled before this edge's updates land.
    always @(posedge i_clk) begin
        string msg;
        if (i_rst_n && o_valid && i_ready) begin
            msg = sb.check_result(o_result_value, o_saturated, o_element_total);
            if (msg != "") report(msg);
        end
    end

    // Receiver: random stall bursts, one long hold-off when asked.
    initial begin
        int n;
        i_ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_request) begin
                i_ready <= 1'b0;
                n = 0;
                while (n < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_request = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    task automatic send_word(logic [31:0] sample, logic last);
        i_valid  <= 1'b1;
        i_sample <= sample;
        i_last   <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(sample, last);
        sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mode(logic [1:0] mode, logic [31:0] mean);
        drain();
        write_reg(vmms_pkg::CFG_MODE, {30'd0, mode});
        write_reg(vmms_pkg::CFG_MEAN, mean);
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'($urandom_range(0, 255)) - 32'd128;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_mean();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'd0;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_vector(int len);
        for (int k = 0; k < len; k++) send_word(pick_sample(), k == len - 1);
    endtask

    initial begin
        int budget;
        int phase;
        logic [1:0] mode;
        sb = new();
        mismatches = 0;
        cycles = 0;
        quiet = 0;
        hold_request = 0;
        sent = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_sample = '0;
        i_last = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = vmms_pkg::CFG_MODE;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes under each mode, deviation difference clamping both ways.
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        set_mode(vmms_pkg::MODE_MAX, 32'd0);
        send_word(32'h8000_0000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b1);
        send_word(32'h8000_0000, 1'b1);
        set_mode(vmms_pkg::MODE_SUM, 32'd0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
        set_mode(vmms_pkg::MODE_SD, 32'h8000_0000);
        send_word(32'h7FFF_FFFF, 1'b0);
        send_word(32'h8000_0000, 1'b1);
        set_mode(vmms_pkg::MODE_SD, 32'h7FFF_FFFF);
        send_word(32'h8000_0000, 1'b1);
        send_word(32'h7FFF_FFFF, 1'b1);
        set_mode(vmms_pkg::MODE_SD, 32'h0001_0000);
        send_word(32'h0003_0000, 1'b0);
        send_word(32'hFFFF_0000, 1'b1);

        // Random phases, each under a fresh mode and mean.
        phase = 0;
        budget = RANDOM_ITEMS;
        while (budget > 0) begin
            mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            if (budget < 160) quiet = 1;
            set_mode(mode, pick_mean());
            if (phase == 2) hold_request = 1;
            for (int start = sent; sent - start < 120 && budget > 0; ) begin
                int len;
                int before_count;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                  : $urandom_range(1, 8);
                before_count = sent;
                send_vector(len);
                budget -= sent - before_count;
            end
            phase++;
        end

        drain();
        if (mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/vmms_pkg.sv
sv/vmms_front.sv
sv/vmms_fifo.sv
sv/vmms_back.sv
sv/vector_min_max_sum_stddev.sv
dv/tb_vector_min_max_sum_stddev.sv
